// ===== rtl/skvt_pkg.sv =====
// shared types and constants for the sorted key/value table
`timescale 1ns / 1ps

package skvt_pkg;

    // table depth and derived widths
    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 64;
    localparam int ENTRY_W  = 6;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int IN_DATA_W  = 2 * WORD_W;
    localparam int OUT_DATA_W = 136;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * WORD_W - ENTRY_W;

    typedef logic [WORD_W-1:0] word_t;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_LIST   = 2'd3
    } cmd_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_FOUND     = 3'd1,
        KIND_NOT_FOUND = 3'd2,
        KIND_DELETED   = 3'd3,
        KIND_ENTRY     = 3'd4,
        KIND_TOTAL     = 3'd5,
        KIND_FULL      = 3'd6
    } kind_t;

    // operation applied to every cell at once
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    // per-cell control from the sequencer
    typedef struct packed {
        cell_op_t op;
        logic     occupied;
        logic     at_end;
        logic     at_tail;
    } cell_ctrl_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } state_t;

endpackage

// ===== rtl/skvt_cell.sv =====
// one table cell: holds a key/value pair and trades it with its neighbors
`timescale 1ns / 1ps

module skvt_cell (
    input  logic               clk,
    input  skvt_pkg::cell_ctrl_t ctrl,
    input  skvt_pkg::word_t    new_key,
    input  skvt_pkg::word_t    new_value,
    input  skvt_pkg::word_t    left_key,
    input  skvt_pkg::word_t    left_value,
    input  logic               left_gt,
    input  logic               left_hit,
    input  skvt_pkg::word_t    right_key,
    input  skvt_pkg::word_t    right_value,
    input  skvt_pkg::word_t    head_key,
    input  skvt_pkg::word_t    head_value,
    output skvt_pkg::word_t    key,
    output skvt_pkg::word_t    value,
    output logic               gt,
    output logic               hit
);
    import skvt_pkg::*;

    word_t key_reg;
    word_t key_next;
    word_t value_reg;
    word_t value_next;
    logic  match;

    // compare against the broadcast key
    assign gt    = ctrl.occupied && (key_reg > new_key);
    assign match = ctrl.occupied && (key_reg == new_key);
    assign hit   = left_hit || match;
    assign key   = key_reg;
    assign value = value_reg;

    // next contents per operation
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                if (left_gt)
                begin
                    key_next   = left_key;
                    value_next = left_value;
                end
                else if (gt || ctrl.at_end)
                begin
                    key_next   = new_key;
                    value_next = new_value;
                end
            end
            CELL_REMOVE:
            begin
                if (ctrl.occupied && hit)
                begin
                    key_next   = right_key;
                    value_next = right_value;
                end
            end
            CELL_ROTATE:
            begin
                if (ctrl.occupied)
                begin
                    key_next   = ctrl.at_tail ? head_key : right_key;
                    value_next = ctrl.at_tail ? head_value : right_value;
                end
            end
        endcase
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// ===== rtl/sorted_key_value_table_unit.sv =====
// top level: sequencer, output register and the row of table cells
`timescale 1ns / 1ps
// add and delete: item taken in the idle state, result registered in the exec state
//   once the output register is free; find and list: the row rotates once through all
//   entries, one entry a cycle while the output register is free
// list emits one entry item per rotation step, then a total item
// rst_n is asynchronous active low: clears the entry count and control state

module sorted_key_value_table_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // key [63:0], value [127:64]
    input  logic [skvt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd [1:0]
    input  logic [skvt_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_key [63:0], out_value [127:64], entry_count [133:128], zero pad
    output logic [skvt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind [2:0]
    output logic [skvt_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast
);
    import skvt_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    cmd_t              cmd_reg;
    word_t             key_reg;
    word_t             value_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic              found_reg;
    logic              found_next;
    word_t             found_value_reg;
    word_t             found_value_next;

    logic              m_valid_reg;
    kind_t             m_kind_reg;
    word_t             m_key_reg;
    word_t             m_value_reg;
    logic [ENTRY_W-1:0] m_count_reg;
    logic              m_last_reg;

    logic              out_free;
    logic              take_in;
    logic              load_out;
    kind_t             out_kind;
    word_t             out_key;
    word_t             out_value;
    logic [CNT_W-1:0]  out_count;
    logic              out_last;
    cell_op_t          cell_op;
    logic              walk_done;
    logic              any_hit;

    word_t             cell_key   [CAPACITY];
    word_t             cell_value [CAPACITY];
    logic              cell_gt    [CAPACITY];
    logic              cell_hit   [CAPACITY];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign walk_done     = (idx_reg == count_reg);
    assign any_hit       = cell_hit[CAPACITY-1];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (cmd_t'(s_axis_tuser) == CMD_ADD || cmd_t'(s_axis_tuser) == CMD_DELETE)
                        state_next = ST_EXEC;
                    else
                        state_next = ST_WALK;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (out_free && walk_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls and result selection
    always_comb
    begin
        cell_op          = CELL_HOLD;
        load_out         = 1'b0;
        out_kind         = KIND_TOTAL;
        out_key          = '0;
        out_value        = '0;
        out_count        = count_reg;
        out_last         = 1'b1;
        count_next       = count_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        found_value_next = found_value_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    out_key  = key_reg;
                    if (cmd_reg == CMD_ADD)
                    begin
                        out_value = value_reg;
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            out_kind = KIND_FULL;
                        end
                        else
                        begin
                            cell_op    = CELL_INSERT;
                            count_next = count_reg + 1'b1;
                            out_count  = count_next;
                            out_kind   = KIND_ADDED;
                        end
                    end
                    else if (any_hit)
                    begin
                        cell_op    = CELL_REMOVE;
                        count_next = count_reg - 1'b1;
                        out_count  = count_next;
                        out_kind   = KIND_DELETED;
                    end
                    else
                    begin
                        out_kind = KIND_NOT_FOUND;
                    end
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    if (!walk_done)
                    begin
                        // head cell is presented, then the row shifts toward it
                        cell_op  = CELL_ROTATE;
                        idx_next = idx_reg + 1'b1;
                        if (cmd_reg == CMD_LIST)
                        begin
                            load_out  = 1'b1;
                            out_kind  = KIND_ENTRY;
                            out_key   = cell_key[0];
                            out_value = cell_value[0];
                            out_last  = 1'b0;
                        end
                        else if (!found_reg && cell_key[0] == key_reg)
                        begin
                            found_next       = 1'b1;
                            found_value_next = cell_value[0];
                        end
                    end
                    else
                    begin
                        load_out = 1'b1;
                        if (cmd_reg == CMD_LIST)
                        begin
                            out_kind = KIND_TOTAL;
                        end
                        else if (found_reg)
                        begin
                            out_kind  = KIND_FOUND;
                            out_key   = key_reg;
                            out_value = found_value_reg;
                        end
                        else
                        begin
                            out_kind = KIND_NOT_FOUND;
                            out_key  = key_reg;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        found_value_reg <= found_value_next;
        if (take_in)
        begin
            cmd_reg   <= cmd_t'(s_axis_tuser);
            key_reg   <= s_axis_tdata[WORD_W-1:0];
            value_reg <= s_axis_tdata[2*WORD_W-1:WORD_W];
        end
        if (load_out)
        begin
            m_kind_reg  <= out_kind;
            m_key_reg   <= out_key;
            m_value_reg <= out_value;
            m_count_reg <= ENTRY_W'(out_count);
            m_last_reg  <= out_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_count_reg, m_value_reg, m_key_reg};

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        word_t      left_key;
        word_t      left_value;
        logic       left_gt;
        logic       left_hit;
        word_t      right_key;
        word_t      right_value;

        assign ctrl.op       = cell_op;
        assign ctrl.occupied = (CNT_W'(i) < count_reg);
        assign ctrl.at_end   = (count_reg == CNT_W'(i));
        assign ctrl.at_tail  = (count_reg == CNT_W'(i + 1));

        if (i == 0)
        begin : g_first
            assign left_key   = '0;
            assign left_value = '0;
            assign left_gt    = 1'b0;
            assign left_hit   = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_key   = cell_key[i-1];
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
            assign left_hit   = cell_hit[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key   = '0;
            assign right_value = '0;
        end
        else
        begin : g_inner_right
            assign right_key   = cell_key[i+1];
            assign right_value = cell_value[i+1];
        end

        skvt_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_key     (key_reg),
            .new_value   (value_reg),
            .left_key    (left_key),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .left_hit    (left_hit),
            .right_key   (right_key),
            .right_value (right_value),
            .head_key    (cell_key[0]),
            .head_value  (cell_value[0]),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .gt          (cell_gt[i]),
            .hit         (cell_hit[i])
        );
    end

`ifndef SYNTHESIS
    // entry count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // walk position never passes the entry count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> idx_reg <= count_reg)
        else $error("walk index past entry count");

    // a successful add grows the table by exactly one
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_free && cmd_reg == CMD_ADD
         && count_reg < CNT_W'(CAPACITY))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not grow the table");

    // only entry items leave last low
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_last_reg |-> m_kind_reg == KIND_ENTRY)
        else $error("non-entry item without last");

    // table stays sorted outside a rotation
    for (genvar j = 0; j + 1 < CAPACITY; j++)
    begin : g_sorted_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            (state_reg != ST_WALK && CNT_W'(j + 1) < count_reg)
            |-> cell_key[j] <= cell_key[j+1])
            else $error("table out of order");
    end
`endif

endmodule

// ===== test/tb_top.sv =====
// testbench for the sorted key/value table: directed script plus checked random traffic
`timescale 1ns / 1ps

module tb_top;

    import skvt_pkg::*;

    localparam int RANDOM_ITEMS  = 360;
    localparam int STALL_LIMIT   = 4000;
    localparam int SINK_HOLD_LEN = 400;
    localparam int TAIL_CYCLES   = 40;
    localparam int IDLE_PCT      = 31;
    localparam int NDIR          = 22;
    localparam int NPOOL         = 6;

    // one result item as seen on the master side
    typedef struct packed {
        kind_t              kind;
        word_t              key;
        word_t              val;
        logic [ENTRY_W-1:0] count;
        logic               last;
    } result_t;

    // one row of the directed script
    typedef struct packed {
        cmd_t    cmd;
        word_t   key;
        word_t   val;
        logic    typed;
        result_t want;
    } script_row_t;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } traffic_mode_t;

    // frequently used keys and values: names in ascii, big-endian, zero padded
    localparam word_t K_ANN  = 64'h616E6E0000000000;
    localparam word_t K_BOB  = 64'h626F620000000000;
    localparam word_t K_ZOE  = 64'h7A6F650000000000;
    localparam word_t K_HOLE = 64'h4100420000000000;
    localparam word_t K_ONES = 64'hFFFFFFFFFFFFFFFF;
    localparam word_t K_ALT5 = 64'h5555555555555555;
    localparam word_t K_ALTA = 64'hAAAAAAAAAAAAAAAA;
    localparam word_t V_555  = 64'h3535350000000000;
    localparam word_t V_123  = 64'h3132330000000000;
    localparam word_t V_777  = 64'h3737370000000000;
    localparam word_t V_9    = 64'h3900000000000000;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = CMD_ADD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    // table model state
    word_t   tbl_key [CAPACITY];
    word_t   tbl_val [CAPACITY];
    int      tbl_fill = 0;
    result_t pending_results [$];

    int error_count   = 0;
    int random_sent   = 0;
    int stall_cycles  = 0;
    bit quiet_run     = 1'b0;
    bit sink_hold_req = 1'b0;

    word_t key_pool [NPOOL] = '{K_ANN, K_BOB, K_ZOE, K_HOLE, 64'h0, K_ONES};

    // directed script, typed expectations where obvious
    script_row_t script [NDIR] = '{
        '{CMD_LIST,   64'h0,  64'h0,  1'b1, '{KIND_TOTAL, 64'h0, 64'h0, 6'd0, 1'b1}},
        '{CMD_FIND,   K_ANN,  64'h0,  1'b1, '{KIND_NOT_FOUND, K_ANN, 64'h0, 6'd0, 1'b1}},
        '{CMD_DELETE, K_ZOE,  K_ONES, 1'b1, '{KIND_NOT_FOUND, K_ZOE, 64'h0, 6'd0, 1'b1}},
        '{CMD_ADD,    64'h0,  K_ONES, 1'b1, '{KIND_ADDED, 64'h0, K_ONES, 6'd1, 1'b1}},
        '{CMD_ADD,    K_ONES, 64'h0,  1'b1, '{KIND_ADDED, K_ONES, 64'h0, 6'd2, 1'b1}},
        '{CMD_ADD,    K_BOB,  V_555,  1'b1, '{KIND_ADDED, K_BOB, V_555, 6'd3, 1'b1}},
        '{CMD_ADD,    K_ANN,  V_123,  1'b1, '{KIND_ADDED, K_ANN, V_123, 6'd4, 1'b1}},
        '{CMD_ADD,    K_BOB,  V_777,  1'b1, '{KIND_ADDED, K_BOB, V_777, 6'd5, 1'b1}},
        '{CMD_ADD,    K_HOLE, V_9,    1'b1, '{KIND_ADDED, K_HOLE, V_9, 6'd6, 1'b1}},
        '{CMD_LIST,   64'h0,  64'h0,  1'b0, '0},
        '{CMD_FIND,   K_BOB,  64'h0,  1'b0, '0},
        '{CMD_DELETE, K_BOB,  64'h0,  1'b1, '{KIND_DELETED, K_BOB, 64'h0, 6'd5, 1'b1}},
        '{CMD_FIND,   K_BOB,  64'h0,  1'b0, '0},
        '{CMD_FIND,   64'h0,  64'h0,  1'b0, '0},
        '{CMD_FIND,   K_ONES, 64'h0,  1'b0, '0},
        '{CMD_DELETE, 64'h0,  64'h0,  1'b1, '{KIND_DELETED, 64'h0, 64'h0, 6'd4, 1'b1}},
        '{CMD_DELETE, K_ONES, 64'h0,  1'b1, '{KIND_DELETED, K_ONES, 64'h0, 6'd3, 1'b1}},
        '{CMD_FIND,   64'h41, 64'h0,  1'b1, '{KIND_NOT_FOUND, 64'h41, 64'h0, 6'd3, 1'b1}},
        '{CMD_ADD,    K_ALT5, K_ALTA, 1'b1, '{KIND_ADDED, K_ALT5, K_ALTA, 6'd4, 1'b1}},
        '{CMD_ADD,    K_ALTA, K_ALT5, 1'b1, '{KIND_ADDED, K_ALTA, K_ALT5, 6'd5, 1'b1}},
        '{CMD_LIST,   64'h0,  64'h0,  1'b0, '0},
        '{CMD_DELETE, K_HOLE, 64'h0,  1'b0, '0}
    };

    sorted_key_value_table_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // table model: apply one command, queue the result items it causes
    task automatic apply_table_cmd(cmd_t c, word_t k, word_t v, bit queue_it);
        int      pos;
        result_t r [$];
        pos = tbl_fill;
        case (c)
            CMD_ADD:
            begin
                if (tbl_fill >= CAPACITY)
                    r.push_back('{KIND_FULL, k, v, ENTRY_W'(tbl_fill), 1'b1});
                else
                begin
                    // insert after any equal keys
                    while (pos > 0 && tbl_key[pos-1] > k)
                    begin
                        tbl_key[pos] = tbl_key[pos-1];
                        tbl_val[pos] = tbl_val[pos-1];
                        pos--;
                    end
                    tbl_key[pos] = k;
                    tbl_val[pos] = v;
                    tbl_fill++;
                    r.push_back('{KIND_ADDED, k, v, ENTRY_W'(tbl_fill), 1'b1});
                end
            end
            CMD_FIND, CMD_DELETE:
            begin
                // first matching entry
                for (int i = 0; i < tbl_fill && pos == tbl_fill; i++)
                    if (tbl_key[i] == k)
                        pos = i;
                if (pos == tbl_fill)
                    r.push_back('{KIND_NOT_FOUND, k, 64'h0, ENTRY_W'(tbl_fill), 1'b1});
                else if (c == CMD_FIND)
                    r.push_back('{KIND_FOUND, tbl_key[pos], tbl_val[pos],
                                  ENTRY_W'(tbl_fill), 1'b1});
                else
                begin
                    for (int i = pos; i + 1 < tbl_fill; i++)
                    begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_val[i] = tbl_val[i+1];
                    end
                    tbl_fill--;
                    r.push_back('{KIND_DELETED, k, 64'h0, ENTRY_W'(tbl_fill), 1'b1});
                end
            end
            default:
            begin
                for (int i = 0; i < tbl_fill; i++)
                    r.push_back('{KIND_ENTRY, tbl_key[i], tbl_val[i],
                                  ENTRY_W'(tbl_fill), 1'b0});
                r.push_back('{KIND_TOTAL, 64'h0, 64'h0, ENTRY_W'(tbl_fill), 1'b1});
            end
        endcase
        if (queue_it)
            foreach (r[i])
                pending_results.push_back(r[i]);
    endtask

    // offer one item, with random gaps, until it is taken
    task automatic send_item(cmd_t c, word_t k, word_t v, bit typed, result_t want);
        while (!quiet_run && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, k};
        s_axis_tuser  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_table_cmd(c, k, v, !typed);
        if (typed)
            pending_results.push_back(want);
    endtask

    // stop offering until every pending result has come
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // key drawn from the table, from the pool of names, or fully random
    function automatic word_t pick_key(int hit_pct);
        int r;
        r = $urandom_range(99);
        if (r < hit_pct && tbl_fill > 0)
            return tbl_key[$urandom_range(tbl_fill - 1)];
        else if (r < hit_pct + (100 - hit_pct) / 2)
            return key_pool[$urandom_range(NPOOL - 1)];
        return rand_word();
    endfunction

    // one random command, weighted by traffic mode
    task automatic send_random(traffic_mode_t mode);
        int   r;
        cmd_t c;
        r = $urandom_range(99);
        case (mode)
            MODE_GROW:   c = r < 75 ? CMD_ADD : r < 85 ? CMD_FIND : r < 90 ? CMD_DELETE : CMD_LIST;
            MODE_SHRINK: c = r < 65 ? CMD_DELETE : r < 80 ? CMD_FIND : r < 88 ? CMD_ADD : CMD_LIST;
            default:     c = r < 35 ? CMD_ADD : r < 60 ? CMD_FIND : r < 85 ? CMD_DELETE : CMD_LIST;
        endcase
        send_item(c, pick_key(c == CMD_ADD ? 30 : 70), rand_word(), 1'b0, '0);
        random_sent++;
    endtask

    // report one mismatch and count it
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result receiver: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_LEN) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            m_axis_tready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare each result item with the oldest pending one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", m_axis_tdata[63:0], 64'h0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
                if (m_axis_tdata[63:0] != want.key)
                    report_mismatch("out_key", m_axis_tdata[63:0], want.key);
                if (m_axis_tdata[127:64] != want.val)
                    report_mismatch("out_value", m_axis_tdata[127:64], want.val);
                if (m_axis_tdata[133:128] != want.count)
                    report_mismatch("entry_count", 64'(m_axis_tdata[133:128]),
                                    64'(want.count));
                if (m_axis_tlast != want.last)
                    report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
            begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int round;
        int n;
        round = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        for (int i = 0; i < NDIR; i++)
            send_item(script[i].cmd, script[i].key, script[i].val,
                      script[i].typed, script[i].want);
        drain_results();

        // receiver holds off while items keep coming
        sink_hold_req = 1'b1;
        repeat (4) send_item(CMD_ADD, pick_key(30), rand_word(), 1'b0, '0);
        send_item(CMD_LIST, 64'h0, 64'h0, 1'b0, '0);
        send_item(CMD_FIND, pick_key(70), 64'h0, 1'b0, '0);
        drain_results();

        // random rounds: fill to full, extra adds, list, empty out, list, then mixed
        // later rounds top the mixed part up to the item budget
        while (random_sent < RANDOM_ITEMS)
        begin
            quiet_run = (round == 1);
            n = 0;
            while (tbl_fill < CAPACITY && n < 150)
            begin
                send_random(MODE_GROW);
                n++;
            end
            repeat (3)
            begin
                send_item(CMD_ADD, pick_key(30), rand_word(), 1'b0, '0);
                random_sent++;
            end
            send_item(CMD_LIST, rand_word(), rand_word(), 1'b0, '0);
            n = 0;
            while (tbl_fill > 0 && n < 200)
            begin
                send_random(MODE_SHRINK);
                n++;
            end
            send_item(CMD_LIST, rand_word(), rand_word(), 1'b0, '0);
            n = 0;
            while (n < 20 || (round > 0 && random_sent < RANDOM_ITEMS))
            begin
                send_random(MODE_MIXED);
                n++;
            end
            if (round == 0)
                drain_results();
            round++;
        end
        quiet_run = 1'b0;

        // wait for the last results and a quiet tail
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sorted_key_value_table_unit.f =====
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table_unit.sv
test/tb_top.sv
